[rtl/izba_pkg.sv]
`default_nettype none

package izba_pkg;

   localparam int OP_W       = 2;
   localparam int NUM_W      = 25;
   localparam int STATUS_W   = 2;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int IMB_W      = 3;
   localparam int ZMB_W      = 4;
   localparam int FDZ_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC_INODE = 2'd0,
      OP_ALLOC_ZONE  = 2'd1,
      OP_FREE_INODE  = 2'd2,
      OP_FREE_ZONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_BELOW = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_INODE_MAP_BLOCKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_MAP_BLOCKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DATA_ZONE  = 2'd2;

   localparam logic [IMB_W-1:0] IMB_RESET = 3'd1;
   localparam logic [ZMB_W-1:0] ZMB_RESET = 4'd1;
   localparam logic [FDZ_W-1:0] FDZ_RESET = 24'd0;

   // position of the lowest clear bit, binary search over halves
   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] v;
      logic [BIT_W-1:0]  pos;
      v   = ~w;
      pos = '0;
      for (int lvl = BIT_W - 1; lvl >= 0; lvl--) begin
         if ((v & ((WORD_W'(1) << (1 << lvl)) - WORD_W'(1))) == '0) begin
            pos[lvl] = 1'b1;
            v        = v >> (1 << lvl);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

[rtl/izba_ifs.sv]
`default_nettype none

interface izba_req_if import izba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [NUM_W-1:0] item_number;

   modport source (output valid, output operation, output item_number, input ready);
   modport sink   (input valid, input operation, input item_number, output ready);
endinterface

interface izba_rsp_if import izba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NUM_W-1:0]    result_number;

   modport source (output valid, output status, output result_number, input ready);
   modport sink   (input valid, input status, input result_number, output ready);
endinterface

`default_nettype wire

[rtl/izba_ram.sv]
`default_nettype none

module izba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/inode_zone_bitmap_allocator_core.sv]
`default_nettype none
// flow: a bad number, or an allocation with no blocks in use, is answered at once from idle;
//   a free reads its word and writes it back, an allocation scans the 32-bit words in use
// throughput: one item at a time, the next is taken in idle once the last result is being or has been taken;
//   the scan reads one bitmap word per cycle through the memory read port
// reset: synchronous; a clearing pass over max(inode, zone) memory depth words
//   (2048 at default sizes) writes both bitmaps before the first item is taken

module inode_zone_bitmap_allocator_core import izba_pkg::*; #(
   parameter int BITS_PER_MAP_BLOCK   = 8192,
   parameter int MAX_INODE_MAP_BLOCKS = 4,
   parameter int MAX_ZONE_MAP_BLOCKS  = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   izba_req_if.sink                   req,
   izba_rsp_if.source                 rsp,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // bitmap geometry in 32-bit words
   localparam int WPB    = BITS_PER_MAP_BLOCK / WORD_W;
   localparam int IDEPTH = MAX_INODE_MAP_BLOCKS * WPB;
   localparam int ZDEPTH = MAX_ZONE_MAP_BLOCKS * WPB;
   localparam int MAXD   = (IDEPTH > ZDEPTH) ? IDEPTH : ZDEPTH;
   localparam int IAW    = $clog2(IDEPTH);
   localparam int ZAW    = $clog2(ZDEPTH);
   localparam int CW     = $clog2(MAXD) + 1;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_FREE  = 4'b0100,
      S_SCAN  = 4'b1000
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic [CW-1:0]        clr_ff, clr_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [IMB_W-1:0]     inode_blocks_ff, inode_blocks_in;
   logic [ZMB_W-1:0]     zone_blocks_ff, zone_blocks_in;
   logic [FDZ_W-1:0]     first_zone_ff, first_zone_in;

   // payload
   op_type               op_ff, op_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [NUM_W-1:0]     rsp_number_ff, rsp_number_in;

   // memory ports
   logic                 inode_we, zone_we;
   logic [CW-1:0]        wr_word, rd_word;
   logic [WORD_W-1:0]    wr_data;
   logic [WORD_W-1:0]    inode_rdata, zone_rdata, rdata;

   // limits and request decode
   logic [CW-1:0]        icnt, zcnt, ilim, zlim, cur_lim, req_lim;
   logic                 cur_zone, req_zone;
   op_type               req_op;
   logic                 req_fire, rsp_load;
   logic [NUM_W:0]       zdiff;
   logic                 zone_below, inode_oor, zone_oor;
   logic [CW-1:0]        fr_word;
   logic [BIT_W-1:0]     fr_bit;
   logic [BIT_W-1:0]     fz;
   logic [CW+BIT_W-1:0]  found_bit;
   logic [CW-1:0]        ptr_next;

   // block counts capped at their maximum, then turned into words in use
   assign icnt = (CW'(inode_blocks_ff) > CW'(MAX_INODE_MAP_BLOCKS)) ?
                 CW'(MAX_INODE_MAP_BLOCKS) : CW'(inode_blocks_ff);
   assign zcnt = (CW'(zone_blocks_ff) > CW'(MAX_ZONE_MAP_BLOCKS)) ?
                 CW'(MAX_ZONE_MAP_BLOCKS) : CW'(zone_blocks_ff);
   assign ilim = icnt * CW'(WPB);
   assign zlim = zcnt * CW'(WPB);

   assign cur_zone = (op_ff == OP_ALLOC_ZONE) || (op_ff == OP_FREE_ZONE);
   assign cur_lim  = cur_zone ? zlim : ilim;
   assign rdata    = cur_zone ? zone_rdata : inode_rdata;

   assign req_op   = op_type'(req.operation);
   assign req_zone = (req_op == OP_ALLOC_ZONE) || (req_op == OP_FREE_ZONE);
   assign req_lim  = req_zone ? zlim : ilim;
   assign req_fire = req.valid && req.ready;

   // zone bit number = zone - first_data_zone + 1; the limit is whole words,
   // so the range check only looks at the word index
   assign zdiff      = {1'b0, req.item_number} - {2'b00, first_zone_ff} + (NUM_W+1)'(1);
   assign zone_below = req.item_number < {1'b0, first_zone_ff};
   assign inode_oor  = (req.item_number == '0) ||
                       (req.item_number[NUM_W-1:BIT_W] >= (NUM_W-BIT_W)'(ilim));
   assign zone_oor   = zdiff[NUM_W:BIT_W] >= (NUM_W+1-BIT_W)'(zlim);
   assign fr_word    = req_zone ? CW'(zdiff[NUM_W:BIT_W]) : CW'(req.item_number[NUM_W-1:BIT_W]);
   assign fr_bit     = req_zone ? zdiff[BIT_W-1:0] : req.item_number[BIT_W-1:0];

   // scan datapath
   assign fz        = first_zero(rdata);
   assign found_bit = {ptr_ff, fz};
   assign ptr_next  = ptr_ff + CW'(1);

   assign req.ready     = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.result_number = rsp_number_ff;

   // configuration writes
   always_comb begin
      inode_blocks_in = inode_blocks_ff;
      zone_blocks_in  = zone_blocks_ff;
      first_zone_in   = first_zone_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_INODE_MAP_BLOCKS: inode_blocks_in = csr_wdata[IMB_W-1:0];
            CSR_ZONE_MAP_BLOCKS:  zone_blocks_in  = csr_wdata[ZMB_W-1:0];
            CSR_FIRST_DATA_ZONE:  first_zone_in   = csr_wdata[FDZ_W-1:0];
            default: ;
         endcase
      end
   end

   // main sequencer: clearing pass, request decode, read-modify-write
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ptr_in        = ptr_ff;
      op_in         = op_ff;
      bit_in        = bit_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_number_in = rsp_number_ff;
      inode_we      = 1'b0;
      zone_we       = 1'b0;
      wr_word       = ptr_ff;
      wr_data       = rdata;
      rd_word       = '0;

      case (state_ff)
         S_CLEAR: begin
            // word 0 gets the reserved entry, every other word is cleared
            inode_we = clr_ff < CW'(IDEPTH);
            zone_we  = clr_ff < CW'(ZDEPTH);
            wr_word  = clr_ff;
            wr_data  = (clr_ff == '0) ? WORD_W'(1) : '0;
            clr_in   = clr_ff + CW'(1);
            if (clr_ff == CW'(MAXD - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               op_in = req_op;
               case (req_op)
                  OP_ALLOC_INODE, OP_ALLOC_ZONE: begin
                     if (req_lim == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_FULL;
                        rsp_number_in = '0;
                     end else begin
                        rd_word  = '0;
                        ptr_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE_INODE: begin
                     if (inode_oor) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_RANGE;
                        rsp_number_in = '0;
                     end else begin
                        rd_word  = fr_word;
                        ptr_in   = fr_word;
                        bit_in   = fr_bit;
                        state_in = S_FREE;
                     end
                  end
                  OP_FREE_ZONE: begin
                     if (zone_below) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_BELOW;
                        rsp_number_in = '0;
                     end else if (zone_oor) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_RANGE;
                        rsp_number_in = '0;
                     end else begin
                        rd_word  = fr_word;
                        ptr_in   = fr_word;
                        bit_in   = fr_bit;
                        state_in = S_FREE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_FREE: begin
            // word arrives this cycle, clear the bit and write it back
            inode_we      = !cur_zone;
            zone_we       = cur_zone;
            wr_word       = ptr_ff;
            wr_data       = rdata & ~(WORD_W'(1) << bit_ff);
            rsp_load      = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_number_in = '0;
            state_in      = S_IDLE;
         end

         S_SCAN: begin
            // next word is fetched while this one is checked
            rd_word = ptr_next;
            if (rdata != '1) begin
               inode_we      = !cur_zone;
               zone_we       = cur_zone;
               wr_word       = ptr_ff;
               wr_data       = rdata | (WORD_W'(1) << fz);
               rsp_load      = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_number_in = cur_zone ?
                               NUM_W'(found_bit) + NUM_W'(first_zone_ff) - NUM_W'(1) :
                               NUM_W'(found_bit);
               state_in      = S_IDLE;
            end else if (ptr_next == cur_lim) begin
               rsp_load      = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_number_in = '0;
               state_in      = S_IDLE;
            end else begin
               ptr_in = ptr_next;
            end
         end

         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_ff          <= '0;
         ptr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         inode_blocks_ff <= IMB_RESET;
         zone_blocks_ff  <= ZMB_RESET;
         first_zone_ff   <= FDZ_RESET;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         ptr_ff          <= ptr_in;
         rsp_valid_ff    <= rsp_valid_in;
         inode_blocks_ff <= inode_blocks_in;
         zone_blocks_ff  <= zone_blocks_in;
         first_zone_ff   <= first_zone_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      bit_ff <= bit_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_number_ff <= rsp_number_in;
      end
   end

   izba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (IDEPTH)
   ) u_inode_map (
      .clock   (clock),
      .wr_en   (inode_we),
      .wr_addr (wr_word[IAW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_word[IAW-1:0]),
      .rd_data (inode_rdata)
   );

   izba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ZDEPTH)
   ) u_zone_map (
      .clock   (clock),
      .wr_en   (zone_we),
      .wr_addr (wr_word[ZAW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_word[ZAW-1:0]),
      .rd_data (zone_rdata)
   );

`ifndef NO_ASSERTIONS
   // no result may appear before the bitmaps are cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("result pending during clearing pass");

   // bitmaps change only while an item or the clearing pass is in work
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (inode_we || zone_we) |-> (state_ff != S_IDLE))
      else $error("bitmap write while idle");

   // the scan never walks past the words in use
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (ptr_ff < cur_lim))
      else $error("scan pointer beyond map");

   // an accepted item is either in work or already answered
   a_item_tracked: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> ((state_ff != S_IDLE) || rsp_valid_ff))
      else $error("accepted item lost");
`endif

endmodule

`default_nettype wire
